// ===== hdl/assert_macros.svh =====
// assertion macros used by the lfo top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/lfo_pkg.sv =====
// lfo package: item types, register codes, state word and waveform table
package lfo_pkg;

	// request codes
	typedef enum logic [1:0] {
		REQ_TICK    = 2'd0,
		REQ_RESTART = 2'd1,
		REQ_QUERY   = 2'd2,
		REQ_PEEK    = 2'd3
	} lfo_req_e;

	// wave shape codes, the two leftover codes give the midpoint
	typedef enum logic [2:0] {
		SHAPE_SINE     = 3'd0,
		SHAPE_TRIANGLE = 3'd1,
		SHAPE_SQUARE   = 3'd2,
		SHAPE_SAW_UP   = 3'd3,
		SHAPE_SAW_DOWN = 3'd4,
		SHAPE_SHOLD    = 3'd5
	} lfo_shape_e;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WAVE_SHAPE  = 3'd0,
		CFG_RATE        = 3'd1,
		CFG_PHASE_SHIFT = 3'd2,
		CFG_DUTY        = 3'd3,
		CFG_FLOOR       = 3'd4,
		CFG_CEILING     = 3'd5,
		CFG_POST_GAP    = 3'd6
	} lfo_cfg_idx_e;

	// phase increment = floor(rate * 65536 / 10000) by scaled reciprocal
	localparam int                 PHASE_INC_W = 14;
	localparam int                 INC_MULT_W  = 27;
	localparam logic [INC_MULT_W-1:0] INC_MULT = 27'd109951163;
	localparam int                 INC_SHIFT   = 24;
	localparam logic [PHASE_INC_W-1:0] INC_RESET = 14'd655;

	localparam logic [2:0] SHAPE_RESET   = 3'd0;
	localparam logic [7:0] SHIFT_RESET   = 8'd0;
	localparam logic [7:0] DUTY_THR_RESET = 8'd128;
	localparam logic [6:0] FLOOR_RESET   = 7'd0;
	localparam logic [6:0] CEILING_RESET = 7'd127;
	localparam logic [7:0] GAP_RESET     = 8'd4;

	localparam logic [6:0] LEVEL_MAX   = 7'd127;
	localparam logic [7:0] BYTE_MAX    = 8'd255;
	localparam logic [7:0] MIDPOINT    = 8'd128;
	localparam logic [7:0] SHOLD_ZONE  = 8'd8;

	typedef struct packed {
		lfo_req_e    req_type;
		logic [7:0]  query_phase;
		logic [7:0]  random_byte;
		logic        suppress_post;
	} lfo_in_t;

	typedef struct packed {
		logic [6:0]  shaped_value;
		logic        post_now;
		logic [7:0]  phase_byte;
	} lfo_out_t;

	// configuration as seen by the datapath
	typedef struct packed {
		logic [2:0]             wave_shape;
		logic [PHASE_INC_W-1:0] phase_inc;
		logic [7:0]             phase_shift;
		logic [7:0]             duty_thr;
		logic [6:0]             out_floor;
		logic [6:0]             out_ceiling;
		logic [7:0]             post_gap;
	} lfo_cfg_t;

	// oscillator state word kept in the state ram
	typedef struct packed {
		logic [15:0] phase_acc;
		logic [7:0]  held_sample;
		logic        armed_done;
		logic [7:0]  last_posted;
		logic [7:0]  ticks_since;
	} lfo_osc_state_t;

	localparam lfo_osc_state_t STATE_RESET = '{
		phase_acc:   16'd0,
		held_sample: 8'd64,
		armed_done:  1'b0,
		last_posted: 8'd0,
		ticks_since: 8'd255
	};

	localparam int         STATE_W     = $bits(lfo_osc_state_t);
	localparam int         STATE_DEPTH = 2;
	localparam int         STATE_AW    = $clog2(STATE_DEPTH);
	localparam logic [STATE_AW-1:0] STATE_ENTRY = '0;

	// quarter-wave sine table
	localparam int SINE_ENTRIES = 64;
	localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES);

	localparam logic [7:0] SINE_QUARTER [SINE_ENTRIES] = '{
		8'd0,   8'd6,   8'd13,  8'd19,  8'd25,  8'd31,  8'd37,  8'd44,
		8'd50,  8'd56,  8'd62,  8'd68,  8'd74,  8'd80,  8'd86,  8'd92,
		8'd98,  8'd103, 8'd109, 8'd115, 8'd120, 8'd126, 8'd131, 8'd136,
		8'd142, 8'd147, 8'd152, 8'd157, 8'd162, 8'd167, 8'd171, 8'd176,
		8'd181, 8'd185, 8'd189, 8'd193, 8'd197, 8'd201, 8'd205, 8'd209,
		8'd212, 8'd216, 8'd219, 8'd222, 8'd225, 8'd228, 8'd231, 8'd234,
		8'd236, 8'd238, 8'd241, 8'd243, 8'd244, 8'd246, 8'd248, 8'd249,
		8'd251, 8'd252, 8'd253, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255
	};

	// full sine wave value at phase byte p, mirrored from the quarter table
	function automatic logic [7:0] sine_at(input logic [7:0] p);
		logic [15:0]           prod;
		logic [SINE_IDX_W-1:0] i;
		logic [SINE_IDX_W-1:0] m;
		logic [7:0]            res;
		prod = 16'(p[5:0]) * 16'(SINE_ENTRIES);
		i    = prod[6 +: SINE_IDX_W];
		m    = SINE_IDX_W'(SINE_ENTRIES - 1) - i;
		unique case (p[7:6])
			2'd0: res = MIDPOINT + (SINE_QUARTER[i] >> 1);
			2'd1: res = MIDPOINT + (SINE_QUARTER[m] >> 1);
			2'd2: res = 8'd127 - (SINE_QUARTER[i] >> 1);
			default: res = 8'd127 - (SINE_QUARTER[m] >> 1);
		endcase
		return res;
	endfunction

endpackage

// ===== hdl/lfo_ram.sv =====
// generic single-port-write ram with registered read
module lfo_ram #(
	parameter int WIDTH = lfo_pkg::STATE_W,
	parameter int DEPTH = lfo_pkg::STATE_DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/lfo_cfg.sv =====
// lfo configuration registers with derived increment and duty threshold
module lfo_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lfo_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lfo_pkg::CFG_DATA_W-1:0]     cfg_data,
	output lfo_pkg::lfo_cfg_t                  cfg
);

	localparam int PROD_W = lfo_pkg::CFG_DATA_W + lfo_pkg::INC_MULT_W;

	lfo_pkg::lfo_cfg_t cfg_q;
	logic [PROD_W-1:0] inc_prod;
	logic [lfo_pkg::PHASE_INC_W-1:0] inc_new;
	logic [6:0] duty;
	logic [7:0] duty_thr_new;

	// rate times 65536/10000 through a reciprocal rounded up, exact over 11 bits
	assign inc_prod = PROD_W'(cfg_data) * PROD_W'(lfo_pkg::INC_MULT);
	assign inc_new  = inc_prod[lfo_pkg::INC_SHIFT +: lfo_pkg::PHASE_INC_W];

	// duty*255/127 equals 2*duty, plus one at full duty
	assign duty         = cfg_data[6:0];
	assign duty_thr_new = {duty, 1'b0} | 8'(duty == lfo_pkg::LEVEL_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wave_shape  <= lfo_pkg::SHAPE_RESET;
			cfg_q.phase_inc   <= lfo_pkg::INC_RESET;
			cfg_q.phase_shift <= lfo_pkg::SHIFT_RESET;
			cfg_q.duty_thr    <= lfo_pkg::DUTY_THR_RESET;
			cfg_q.out_floor   <= lfo_pkg::FLOOR_RESET;
			cfg_q.out_ceiling <= lfo_pkg::CEILING_RESET;
			cfg_q.post_gap    <= lfo_pkg::GAP_RESET;
		end else if (cfg_we) begin
			unique case (lfo_pkg::lfo_cfg_idx_e'(cfg_index))
				lfo_pkg::CFG_WAVE_SHAPE:  cfg_q.wave_shape  <= cfg_data[2:0];
				lfo_pkg::CFG_RATE:        cfg_q.phase_inc   <= inc_new;
				lfo_pkg::CFG_PHASE_SHIFT: cfg_q.phase_shift <= cfg_data[7:0];
				lfo_pkg::CFG_DUTY:        cfg_q.duty_thr    <= duty_thr_new;
				lfo_pkg::CFG_FLOOR:       cfg_q.out_floor   <= cfg_data[6:0];
				lfo_pkg::CFG_CEILING:     cfg_q.out_ceiling <= cfg_data[6:0];
				lfo_pkg::CFG_POST_GAP:    cfg_q.post_gap    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/lfo_step.sv =====
// lfo step logic: state update, shape, scaling and post decision for one item
module lfo_step (
	input  lfo_pkg::lfo_cfg_t       cfg,
	input  lfo_pkg::lfo_in_t        item,
	input  lfo_pkg::lfo_osc_state_t cur,
	output lfo_pkg::lfo_osc_state_t nxt,
	output lfo_pkg::lfo_out_t       res
);

	logic        is_tick;
	logic        is_restart;
	logic        is_query;
	logic [15:0] acc_new;
	logic [7:0]  p;
	logic [7:0]  held_new;
	logic        armed_new;
	logic [7:0]  raw;
	logic [6:0]  span;
	logic [14:0] prod;
	logic [15:0] quot_sum;
	logic [7:0]  mid_sum;
	logic [6:0]  val;
	logic [7:0]  ticks_sat;
	logic        post;

	assign is_tick    = (item.req_type == lfo_pkg::REQ_TICK);
	assign is_restart = (item.req_type == lfo_pkg::REQ_RESTART);
	assign is_query   = (item.req_type == lfo_pkg::REQ_QUERY);

	always_comb begin
		if (is_tick) begin
			acc_new = cur.phase_acc + 16'(cfg.phase_inc);
		end else if (is_restart) begin
			acc_new = '0;
		end else begin
			acc_new = cur.phase_acc;
		end
	end

	assign p = (is_query ? item.query_phase : acc_new[15:8]) + cfg.phase_shift;

	// sample-hold latches once near phase zero, rearms in the second half
	always_comb begin
		held_new  = cur.held_sample;
		armed_new = is_restart ? 1'b0 : cur.armed_done;
		if (is_tick && cfg.wave_shape == lfo_pkg::SHAPE_SHOLD) begin
			if (p < lfo_pkg::SHOLD_ZONE && !cur.armed_done) begin
				held_new  = item.random_byte;
				armed_new = 1'b1;
			end else if (p[7]) begin
				armed_new = 1'b0;
			end
		end
	end

	always_comb begin
		unique case (cfg.wave_shape)
			lfo_pkg::SHAPE_SINE:     raw = lfo_pkg::sine_at(p);
			lfo_pkg::SHAPE_TRIANGLE: raw = p[7] ? ~{p[6:0], 1'b0} : {p[6:0], 1'b0};
			lfo_pkg::SHAPE_SQUARE:   raw = (p < cfg.duty_thr) ? lfo_pkg::BYTE_MAX : 8'd0;
			lfo_pkg::SHAPE_SAW_UP:   raw = p;
			lfo_pkg::SHAPE_SAW_DOWN: raw = ~p;
			lfo_pkg::SHAPE_SHOLD:    raw = held_new;
			default:                 raw = lfo_pkg::MIDPOINT;
		endcase
	end

	// x/255 as (x + 1 + x/256)/256, exact for x below 32768
	assign span     = cfg.out_ceiling - cfg.out_floor;
	assign prod     = 15'(raw) * 15'(span);
	assign quot_sum = 16'(prod) + 16'd1 + 16'(prod[14:8]);
	assign mid_sum  = 8'(cfg.out_floor) + 8'(cfg.out_ceiling);

	always_comb begin
		if (cfg.out_floor > cfg.out_ceiling) begin
			val = mid_sum[7:1];
		end else if (cfg.out_floor == '0 && cfg.out_ceiling == lfo_pkg::LEVEL_MAX) begin
			val = raw[7:1];
		end else begin
			val = cfg.out_floor + quot_sum[14:8];
		end
	end

	assign ticks_sat = (cur.ticks_since == lfo_pkg::BYTE_MAX) ? cur.ticks_since
		: cur.ticks_since + 8'd1;
	assign post = is_tick && !item.suppress_post && ticks_sat >= cfg.post_gap
		&& {1'b0, val} != cur.last_posted;

	always_comb begin
		nxt.phase_acc   = acc_new;
		nxt.held_sample = held_new;
		nxt.armed_done  = armed_new;
		if (is_restart) begin
			nxt.last_posted = lfo_pkg::BYTE_MAX;
		end else if (post) begin
			nxt.last_posted = {1'b0, val};
		end else begin
			nxt.last_posted = cur.last_posted;
		end
		if (post) begin
			nxt.ticks_since = '0;
		end else if (is_tick) begin
			nxt.ticks_since = ticks_sat;
		end else begin
			nxt.ticks_since = cur.ticks_since;
		end
	end

	assign res.shaped_value = val;
	assign res.post_now     = post;
	assign res.phase_byte   = acc_new[15:8];

endmodule

// ===== hdl/lfo_waveform_generator_unit.sv =====
// lfo waveform generator top level: state ram, step pipeline and output register
//
//  channel | signals                        | accepted when
//  --------+--------------------------------+------------------------------
//  input   | in_valid, in_ready, in_item    | in_valid && in_ready
//  output  | out_valid, out_ready, out_item | out_valid && out_ready
//  config  | cfg_we, cfg_index, cfg_data    | cfg_we, no wait
//
// an item is accepted into stage s1 while the state ram read is issued; its
// result enters the output register when s1 advances, and a new item may enter
// every cycle while the output is not stalled
// a write-back that lands on the same edge as the next read is forwarded
// reset clears control only; the state reads as its reset value until the
// first write-back; a stalled output holds s1, in_ready drops when both are full
`include "assert_macros.svh"

module lfo_waveform_generator_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  lfo_pkg::lfo_in_t               in_item,
	output logic                           out_valid,
	input  logic                           out_ready,
	output lfo_pkg::lfo_out_t              out_item,
	input  logic                           cfg_we,
	input  logic [lfo_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lfo_pkg::CFG_DATA_W-1:0] cfg_data
);

	lfo_pkg::lfo_cfg_t       cfg;
	lfo_pkg::lfo_in_t        s1_item_s1;
	lfo_pkg::lfo_osc_state_t ram_rdata;
	lfo_pkg::lfo_osc_state_t cur_state;
	lfo_pkg::lfo_osc_state_t nxt_state;
	lfo_pkg::lfo_osc_state_t bypass_q;
	lfo_pkg::lfo_out_t       step_res;
	lfo_pkg::lfo_out_t       out_item_q;

	logic s1_v_q;      // item waiting in s1 with its state read issued
	logic fwd_s1;      // the s1 item's ram read raced a write-back
	logic init_q;      // state ram holds a written word
	logic out_v_q;
	logic adv;         // s1 moves into the output register
	logic accept;
	logic ram_we;

	// handshake: s1 frees when the output register can take its result
	assign adv      = !out_v_q || out_ready;
	assign in_ready = !s1_v_q || adv;
	assign accept   = in_valid && in_ready;
	assign ram_we   = s1_v_q && adv;

	lfo_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// state ram: read on accept, written back when the item leaves s1
	lfo_ram #(
		.WIDTH (lfo_pkg::STATE_W),
		.DEPTH (lfo_pkg::STATE_DEPTH)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (lfo_pkg::STATE_ENTRY),
		.wdata (nxt_state),
		.re    (accept),
		.raddr (lfo_pkg::STATE_ENTRY),
		.rdata (ram_rdata)
	);

	// reset value until first write, then bypass if the read saw stale data
	always_comb begin
		if (!init_q) begin
			cur_state = lfo_pkg::STATE_RESET;
		end else if (fwd_s1) begin
			cur_state = bypass_q;
		end else begin
			cur_state = ram_rdata;
		end
	end

	lfo_step u_step (
		.cfg  (cfg),
		.item (s1_item_s1),
		.cur  (cur_state),
		.nxt  (nxt_state),
		.res  (step_res)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			fwd_s1  <= 1'b0;
			init_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (in_ready) begin
				s1_v_q <= in_valid;
			end
			if (accept) begin
				fwd_s1 <= ram_we;
			end
			if (ram_we) begin
				init_q <= 1'b1;
			end
			if (adv) begin
				out_v_q <= s1_v_q;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_item_s1 <= in_item;
		end
		if (ram_we) begin
			bypass_q   <= nxt_state;
			out_item_q <= step_res;
		end
	end

	assign out_valid = out_v_q;
	assign out_item  = out_item_q;

	`ASSERT_CLK(a_full_stall_blocks_input, (s1_v_q && out_v_q && !out_ready) |-> !in_ready, "input taken while s1 and output are both stalled")
	`ASSERT_CLK(a_write_race_forwards, (accept && ram_we) |=> fwd_s1, "write-back racing a read was not marked for forwarding")
	`ASSERT_CLK(a_post_only_on_tick, (s1_v_q && step_res.post_now) |-> (s1_item_s1.req_type == lfo_pkg::REQ_TICK), "post flagged for a request that is not a tick")
	`ASSERT_CLK(a_output_after_write, !out_v_q || init_q, "result shown before any state write-back")

endmodule
